>>> rtl/bws_pkg.sv
// ----------------------------------------------------------------------------
// bws_pkg: shared types and constants of the bank window splitter
// Field widths, configuration limits, register indexes, item types and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package bws_pkg;

	// Field widths.
	localparam int COORD_W   = 13;
	localparam int STRIDE_W  = 15;
	localparam int BANK_W    = 21;
	localparam int SHIFT_W   = 2;
	localparam int BANKNUM_W = 5;
	localparam int BANKQ_W   = 6;
	localparam int CNT_W     = 6;
	localparam int STEP_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = COORD_W + STRIDE_W;
	localparam int LBYTE_W   = PROD_W + 1;

	// Frame buffer geometry and limits.
	localparam logic [LBYTE_W-1:0]   FRAME_BYTES = LBYTE_W'(1048576);
	localparam logic [COORD_W-1:0]   COORD_MAX   = 13'd4096;
	localparam logic [CNT_W-1:0]     SEG_LAST_IX = 6'd63;
	localparam logic [STRIDE_W-1:0]  STRIDE_MAX  = 15'd16384;
	localparam logic [BANK_W-1:0]    BANK_MIN    = 21'd32768;
	localparam logic [BANK_W-1:0]    BANK_MAX    = 21'd1048576;
	localparam logic [SHIFT_W-1:0]   SHIFT_MAX   = 2'd2;
	localparam logic [STEP_W-1:0]    DIV_LAST    = 5'd20;

	// Register reset values.
	localparam logic [STRIDE_W-1:0]  STRIDE_RST  = 15'd1024;
	localparam logic [BANK_W-1:0]    BANK_RST    = 21'd65536;
	localparam logic [SHIFT_W-1:0]   SHIFT_RST   = 2'd0;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BANK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] rect_left;
		logic [COORD_W-1:0] rect_top;
		logic [COORD_W-1:0] rect_right;
		logic [COORD_W-1:0] rect_bottom;
	} rect_t;

	typedef struct packed {
		logic [BANKNUM_W-1:0] bank_number;
		logic [BANK_W-1:0]    bank_offset;
		logic [COORD_W-1:0]   seg_left;
		logic [COORD_W-1:0]   seg_right;
		logic [COORD_W-1:0]   seg_top;
		logic [COORD_W-1:0]   seg_bottom;
		logic                 broken_part;
		logic                 out_of_range;
		logic                 last;
	} seg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_DIV_BANK,
		S_BANK,
		S_SPLIT,
		S_DIV_SCAN,
		S_ROWS,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/bank_window_splitter_core.sv
// ----------------------------------------------------------------------------
// bank_window_splitter_core: splits a drawing rectangle into bank segments
// A small sequencer drives one multiplier and one shared restoring divider
// to find, segment by segment, the bank and the scans that fit in it.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | in_valid, in_stall, in_data      | rectangle items in
//  output   | out_valid, out_stall, out_data   | segment items out
//  config   | cfg_we, cfg_index, cfg_data      | register writes
//
// An item is accepted in idle and checked in the next cycle. A bad or empty
// rectangle shows its single segment in the cycle after the check. A run of
// whole scans costs two 21-step passes of the shared divider. A broken scan
// costs one pass for both halves. Up to 64 segments per item. Reset restores
// the configuration registers to their defaults and returns the sequencer to
// idle. in_stall stays high until the last segment of an item has been taken.
`default_nettype none

module bank_window_splitter_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [bws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [bws_pkg::BANK_W-1:0]       cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  bws_pkg::rect_t                  in_data,
	output logic                            out_valid,
	input  wire                             out_stall,
	output bws_pkg::seg_t                   out_data
);

	// Configuration registers.
	logic [bws_pkg::STRIDE_W-1:0] stride_q;
	logic [bws_pkg::BANK_W-1:0]   bank_bytes_q;
	logic [bws_pkg::SHIFT_W-1:0]  shift_q;

	// Sequencer and working registers.
	bws_pkg::state_t              state_q, state_d;
	bws_pkg::rect_t               rect_q;
	bws_pkg::seg_t                out_q;
	logic [bws_pkg::COORD_W-1:0]  top_q;
	logic [bws_pkg::STRIDE_W-1:0] scan_q;
	logic [bws_pkg::BANK_W-1:0]   off_q;
	logic [bws_pkg::BANK_W-1:0]   rem_q;
	logic [bws_pkg::BANK_W-1:0]   quo_q;
	logic [bws_pkg::STEP_W-1:0]   step_q;
	logic [bws_pkg::BANKQ_W-1:0]  seg_bank_q;
	logic [bws_pkg::BANK_W-1:0]   boff_q;
	logic [bws_pkg::BANK_W-1:0]   remb_q;
	logic [bws_pkg::COORD_W-1:0]  mid_q;
	logic                         half_q;
	logic [bws_pkg::CNT_W-1:0]    count_q;

	logic in_take, out_take;

	assign in_stall  = (state_q != bws_pkg::S_IDLE);
	assign out_valid = (state_q == bws_pkg::S_OUT);
	assign out_data  = out_q;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid && !out_stall;

	// Shared multiplier: last scan for the range check, current scan otherwise.
	logic [bws_pkg::COORD_W-1:0]  mul_a;
	logic [bws_pkg::PROD_W-1:0]   mul_p;
	logic [bws_pkg::STRIDE_W-1:0] left_sh, right_sh;
	logic [bws_pkg::LBYTE_W-1:0]  last_byte, off_sum;

	assign mul_a     = (state_q == bws_pkg::S_CHECK) ?
	                   rect_q.rect_bottom - 13'd1 : top_q;
	assign mul_p     = bws_pkg::PROD_W'(mul_a) * bws_pkg::PROD_W'(stride_q);
	assign left_sh   = bws_pkg::STRIDE_W'(rect_q.rect_left) << shift_q;
	assign right_sh  = bws_pkg::STRIDE_W'(rect_q.rect_right) << shift_q;
	assign last_byte = bws_pkg::LBYTE_W'(mul_p) + bws_pkg::LBYTE_W'(right_sh);
	assign off_sum   = bws_pkg::LBYTE_W'(mul_p) + bws_pkg::LBYTE_W'(left_sh);

	// Configuration and rectangle checks.
	logic cfg_bad, rect_bad, check_err, is_empty;

	assign cfg_bad = (stride_q == '0) || (stride_q > bws_pkg::STRIDE_MAX) ||
	                 (bank_bytes_q < bws_pkg::BANK_MIN) ||
	                 (bank_bytes_q > bws_pkg::BANK_MAX) ||
	                 (bank_bytes_q <= bws_pkg::BANK_W'(stride_q)) ||
	                 (shift_q > bws_pkg::SHIFT_MAX);
	assign rect_bad = (rect_q.rect_left > rect_q.rect_right) ||
	                  (rect_q.rect_top > rect_q.rect_bottom) ||
	                  (rect_q.rect_right > bws_pkg::COORD_MAX) ||
	                  (rect_q.rect_bottom > bws_pkg::COORD_MAX) ||
	                  ((rect_q.rect_top < rect_q.rect_bottom) &&
	                   (last_byte > bws_pkg::FRAME_BYTES));
	assign check_err = cfg_bad || rect_bad;
	assign is_empty  = (rect_q.rect_top == rect_q.rect_bottom);

	// Shared restoring divider, one quotient bit per cycle.
	logic [bws_pkg::BANK_W-1:0] div_d, rem_n, quo_n;
	logic [bws_pkg::BANK_W:0]   div_sh;
	logic [bws_pkg::BANK_W+1:0] div_diff;
	logic                       div_ge, div_done;

	assign div_d    = (state_q == bws_pkg::S_DIV_BANK) ?
	                  bank_bytes_q : bws_pkg::BANK_W'(stride_q);
	assign div_sh   = {rem_q, quo_q[bws_pkg::BANK_W-1]};
	assign div_diff = {1'b0, div_sh} - {2'b00, div_d};
	assign div_ge   = !div_diff[bws_pkg::BANK_W+1];
	assign rem_n    = div_ge ? div_diff[bws_pkg::BANK_W-1:0] :
	                  div_sh[bws_pkg::BANK_W-1:0];
	assign quo_n    = {quo_q[bws_pkg::BANK_W-2:0], div_ge};
	assign div_done = (step_q == '0);

	// Broken scan test and the end of its first half.
	logic                         is_broken;
	logic [bws_pkg::COORD_W-1:0]  mid;
	logic [bws_pkg::BANK_W-1:0]   remb_px;

	assign is_broken = remb_q < bws_pkg::BANK_W'(scan_q);
	assign remb_px   = remb_q >> shift_q;
	assign mid       = rect_q.rect_left + remb_px[bws_pkg::COORD_W-1:0];

	// Whole scans: quotient, plus the last scan when its drawn part fits.
	logic [bws_pkg::BANK_W:0]     rows_n, segb_full;
	logic                         rows_fin;
	logic [bws_pkg::COORD_W-1:0]  segb;

	assign rows_n    = bws_pkg::BANK_W'(quo_q) +
	                   (bws_pkg::BANK_W+1)'(rem_q >= bws_pkg::BANK_W'(scan_q));
	assign segb_full = (bws_pkg::BANK_W+1)'(top_q) + rows_n;
	assign rows_fin  = segb_full >= (bws_pkg::BANK_W+1)'(rect_q.rect_bottom);
	assign segb      = rows_fin ? rect_q.rect_bottom :
	                   segb_full[bws_pkg::COORD_W-1:0];

	// Continuation half of a broken scan.
	logic [bws_pkg::BANKQ_W-1:0]  bank_next;
	logic [bws_pkg::BANK_W:0]     boff_next;
	logic [bws_pkg::COORD_W-1:0]  top_inc;
	logic                         half_fin;

	assign bank_next = seg_bank_q + 6'd1;
	assign boff_next = (bws_pkg::BANK_W+1)'(boff_q) +
	                   (bws_pkg::BANK_W+1)'(bank_bytes_q);
	assign top_inc   = top_q + 13'd1;
	assign half_fin  = top_inc >= rect_q.rect_bottom;

	// Next state and the segment to load into the output register.
	logic          ld_en, seg_cut;
	bws_pkg::seg_t ld_seg, ld_out;

	always_comb begin
		state_d = state_q;
		ld_en   = 1'b0;
		ld_seg  = '0;
		case (state_q)
			bws_pkg::S_IDLE: begin
				if (in_take) begin
					state_d = bws_pkg::S_CHECK;
				end
			end
			bws_pkg::S_CHECK: begin
				if (check_err || is_empty) begin
					ld_en               = 1'b1;
					ld_seg.seg_left     = rect_q.rect_left;
					ld_seg.seg_right    = rect_q.rect_right;
					ld_seg.seg_top      = rect_q.rect_top;
					ld_seg.seg_bottom   = rect_q.rect_bottom;
					ld_seg.out_of_range = check_err;
					ld_seg.last         = 1'b1;
					state_d             = bws_pkg::S_OUT;
				end else begin
					state_d = bws_pkg::S_MUL;
				end
			end
			bws_pkg::S_MUL: begin
				state_d = bws_pkg::S_DIV_BANK;
			end
			bws_pkg::S_DIV_BANK: begin
				if (div_done) begin
					state_d = bws_pkg::S_BANK;
				end
			end
			bws_pkg::S_BANK: begin
				state_d = bws_pkg::S_SPLIT;
			end
			bws_pkg::S_SPLIT: begin
				if (is_broken) begin
					ld_en              = 1'b1;
					ld_seg.bank_number = seg_bank_q[bws_pkg::BANKNUM_W-1:0];
					ld_seg.bank_offset = boff_q;
					ld_seg.seg_left    = rect_q.rect_left;
					ld_seg.seg_right   = mid;
					ld_seg.seg_top     = top_q;
					ld_seg.seg_bottom  = top_inc;
					ld_seg.broken_part = 1'b1;
					state_d            = bws_pkg::S_OUT;
				end else begin
					state_d = bws_pkg::S_DIV_SCAN;
				end
			end
			bws_pkg::S_DIV_SCAN: begin
				if (div_done) begin
					state_d = bws_pkg::S_ROWS;
				end
			end
			bws_pkg::S_ROWS: begin
				ld_en              = 1'b1;
				ld_seg.bank_number = seg_bank_q[bws_pkg::BANKNUM_W-1:0];
				ld_seg.bank_offset = boff_q;
				ld_seg.seg_left    = rect_q.rect_left;
				ld_seg.seg_right   = rect_q.rect_right;
				ld_seg.seg_top     = top_q;
				ld_seg.seg_bottom  = segb;
				ld_seg.last        = rows_fin;
				state_d            = bws_pkg::S_OUT;
			end
			bws_pkg::S_OUT: begin
				if (out_take) begin
					if (out_q.last) begin
						state_d = bws_pkg::S_IDLE;
					end else if (half_q) begin
						ld_en              = 1'b1;
						ld_seg.bank_number = bank_next[bws_pkg::BANKNUM_W-1:0];
						ld_seg.bank_offset = boff_next[bws_pkg::BANK_W-1:0];
						ld_seg.seg_left    = mid_q;
						ld_seg.seg_right   = rect_q.rect_right;
						ld_seg.seg_top     = top_q;
						ld_seg.seg_bottom  = top_inc;
						ld_seg.broken_part = 1'b1;
						ld_seg.last        = half_fin;
					end else begin
						state_d = bws_pkg::S_MUL;
					end
				end
			end
			default: begin
				state_d = bws_pkg::S_IDLE;
			end
		endcase
	end

	// The segment limit forces the last flag and marks a cut-off run.
	assign seg_cut = (count_q == bws_pkg::SEG_LAST_IX) && !ld_seg.last;

	always_comb begin
		ld_out              = ld_seg;
		ld_out.last         = ld_seg.last || seg_cut;
		ld_out.out_of_range = ld_seg.out_of_range || seg_cut;
	end

	// Control registers: configuration, state, segment count, pending half.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q     <= bws_pkg::STRIDE_RST;
			bank_bytes_q <= bws_pkg::BANK_RST;
			shift_q      <= bws_pkg::SHIFT_RST;
			state_q      <= bws_pkg::S_IDLE;
			count_q      <= '0;
			half_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bws_pkg::REG_STRIDE: stride_q     <= cfg_data[bws_pkg::STRIDE_W-1:0];
					bws_pkg::REG_BANK:   bank_bytes_q <= cfg_data;
					bws_pkg::REG_SHIFT:  shift_q      <= cfg_data[bws_pkg::SHIFT_W-1:0];
					default: begin
					end
				endcase
			end
			state_q <= state_d;
			if (in_take) begin
				count_q <= '0;
				half_q  <= 1'b0;
			end else if (ld_en) begin
				count_q <= count_q + 6'd1;
				half_q  <= (state_q == bws_pkg::S_SPLIT);
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			rect_q <= in_data;
			top_q  <= in_data.rect_top;
		end
		if (ld_en) begin
			out_q <= ld_out;
		end
		case (state_q)
			bws_pkg::S_CHECK: begin
				scan_q <= bws_pkg::STRIDE_W'(rect_q.rect_right - rect_q.rect_left)
				          << shift_q;
			end
			bws_pkg::S_MUL: begin
				off_q  <= off_sum[bws_pkg::BANK_W-1:0];
				rem_q  <= '0;
				quo_q  <= off_sum[bws_pkg::BANK_W-1:0];
				step_q <= bws_pkg::DIV_LAST;
			end
			bws_pkg::S_DIV_BANK, bws_pkg::S_DIV_SCAN: begin
				rem_q  <= rem_n;
				quo_q  <= quo_n;
				step_q <= step_q - 5'd1;
			end
			bws_pkg::S_BANK: begin
				seg_bank_q <= quo_q[bws_pkg::BANKQ_W-1:0];
				boff_q     <= off_q - rem_q;
				remb_q     <= bank_bytes_q - rem_q;
			end
			bws_pkg::S_SPLIT: begin
				if (is_broken) begin
					mid_q <= mid;
				end else begin
					rem_q  <= '0;
					quo_q  <= remb_q;
					step_q <= bws_pkg::DIV_LAST;
				end
			end
			bws_pkg::S_ROWS: begin
				top_q <= segb;
			end
			bws_pkg::S_OUT: begin
				if (out_take && !out_q.last && half_q) begin
					top_q <= top_inc;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
